>>> src/fga_pkg.sv
// Shared constants, codes and control structs of the per-gene Fano accumulator.
`timescale 1ns / 1ps
package fga_pkg;

  localparam int GENES   = 4096;
  localparam int GENE_W  = $clog2(GENES);
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 20;
  localparam int SQV_W   = 2 * VALUE_W;
  localparam int S1_W    = 40;
  localparam int S2_W    = 60;
  localparam int CELLS_W = 21;
  localparam int FANO_W  = 40;
  localparam int FRAC_SH = 8;

  // Widths of the shift-add multiplier and of the three products.
  localparam int MUL_A_W = S2_W;
  localparam int MUL_B_W = S1_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int NS2_W   = CELLS_W + S2_W;
  localparam int SQ_W    = 2 * S1_W;
  localparam int NS1_W   = CELLS_W + S1_W;

  // Widths of the restoring divider.
  localparam int NUM_W   = NS2_W + FRAC_SH;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_LOAD,
    ST_CHECK,
    ST_MUL_NS2,
    ST_MUL_SQ,
    ST_MUL_NS1,
    ST_COMPARE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_NS2,
    MUL_SQ,
    MUL_NS1
  } mul_sel_t;

  typedef struct packed {
    logic [S1_W-1:0] s1;
    logic [S2_W-1:0] s2;
  } sums_t;

  typedef struct packed {
    logic     latch_in;
    logic     clr_wr;
    logic     mem_rd;
    logic     acc_wr;
    logic     load_sums;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     mul_save;
    logic     div_start;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic zero_case;
    logic mul_done;
    logic num_pos;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

>>> src/fga_req_if.sv
// Request channel interface: request type, gene and value.
`timescale 1ns / 1ps
interface fga_req_if;
  import fga_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [GENE_W-1:0]  gene;
  logic [VALUE_W-1:0] value;

  modport source(output valid, req_type, gene, value, input ready);
  modport sink(input valid, req_type, gene, value, output ready);
endinterface

>>> src/fga_res_if.sv
// Result channel interface: gene echo, Fano factor and flags.
`timescale 1ns / 1ps
interface fga_res_if;
  import fga_pkg::*;

  logic              valid;
  logic              ready;
  logic [GENE_W-1:0] gene_echo;
  logic [FANO_W-1:0] fano;
  logic              zero_mean;
  logic              saturated;

  modport source(output valid, gene_echo, fano, zero_mean, saturated, input ready);
  modport sink(input valid, gene_echo, fano, zero_mean, saturated, output ready);
endinterface

>>> src/fga_ctrl.sv
// Controller state machine that sequences the accumulator datapath.
`timescale 1ns / 1ps
module fga_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [fga_pkg::REQ_W-1:0] in_req_type,
  input  fga_pkg::status_t          status,
  output logic                      in_ready,
  output fga_pkg::cmd_t             cmd,
  output fga_pkg::state_t           state
);
  import fga_pkg::*;

  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // State register; reset starts the clearing pass over the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_ACC:   state_next = ST_ACC_RD;
            REQ_READ:  state_next = ST_RD_RD;
            REQ_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD:  state_next = ST_ACC_WR;
      ST_ACC_WR:  state_next = ST_IDLE;
      ST_RD_RD:   state_next = ST_RD_LOAD;
      ST_RD_LOAD: state_next = ST_CHECK;
      ST_CHECK:   state_next = status.zero_case ? ST_DONE : ST_MUL_NS2;
      ST_MUL_NS2: begin
        if (status.mul_done) state_next = ST_MUL_SQ;
      end
      ST_MUL_SQ: begin
        if (status.mul_done) state_next = ST_MUL_NS1;
      end
      ST_MUL_NS1: begin
        if (status.mul_done) state_next = ST_COMPARE;
      end
      ST_COMPARE: state_next = status.num_pos ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (status.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MUL_NS2;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_CLEAR:   cmd.clr_wr = 1'b1;
      ST_IDLE:    cmd.latch_in = accept;
      ST_ACC_RD:  cmd.mem_rd = 1'b1;
      ST_ACC_WR:  cmd.acc_wr = 1'b1;
      ST_RD_RD:   cmd.mem_rd = 1'b1;
      ST_RD_LOAD: cmd.load_sums = 1'b1;
      ST_CHECK: begin
        cmd.mul_start = !status.zero_case;
        cmd.mul_sel   = MUL_NS2;
      end
      ST_MUL_NS2: begin
        cmd.mul_step  = !status.mul_done;
        cmd.mul_save  = status.mul_done;
        cmd.mul_start = status.mul_done;
        cmd.mul_sel   = MUL_SQ;
      end
      ST_MUL_SQ: begin
        cmd.mul_step  = !status.mul_done;
        cmd.mul_save  = status.mul_done;
        cmd.mul_start = status.mul_done;
        cmd.mul_sel   = MUL_NS1;
      end
      ST_MUL_NS1: begin
        cmd.mul_step = !status.mul_done;
        cmd.mul_save = status.mul_done;
      end
      ST_COMPARE: cmd.div_start = status.num_pos;
      ST_DIV:     cmd.div_step = !status.div_done;
      ST_DONE:    cmd.out_load = !status.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> src/fga_dp.sv
// Datapath: sum table, accumulate adders, shift-add multiplier, divider, result register.
`timescale 1ns / 1ps
module fga_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fga_pkg::CELLS_W-1:0] cfg_wdata,
  input  logic [fga_pkg::GENE_W-1:0]  in_gene,
  input  logic [fga_pkg::VALUE_W-1:0] in_value,
  input  fga_pkg::cmd_t               cmd,
  output fga_pkg::status_t            status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [fga_pkg::GENE_W-1:0]  out_gene_echo,
  output logic [fga_pkg::FANO_W-1:0]  out_fano,
  output logic                        out_zero_mean,
  output logic                        out_saturated
);
  import fga_pkg::*;

  sums_t              mem [GENES];
  sums_t              rd_data;
  sums_t              acc_entry;
  logic [GENE_W-1:0]  clr_addr;
  logic [CELLS_W-1:0] total_cells;
  logic [GENE_W-1:0]  gene_reg;
  logic [VALUE_W-1:0] value_reg;
  logic [S1_W-1:0]    s1_reg;
  logic [S2_W-1:0]    s2_reg;
  logic [S1_W:0]      s1_sum;
  logic [S2_W:0]      s2_sum;
  logic [SQV_W-1:0]   value_sq;

  logic [MUL_P_W-1:0] mul_acc;
  logic [MUL_P_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  mul_sel_t           mul_sel_reg;
  logic [NS2_W-1:0]   prod_ns2;
  logic [SQ_W-1:0]    prod_sq;
  logic [NS1_W-1:0]   prod_ns1;

  logic [NUM_W-1:0]   num_sh;
  logic [NS1_W-1:0]   rem;
  logic [NS1_W:0]     rem_sh;
  logic               rem_ge;
  logic [FANO_W-1:0]  quot;
  logic               quot_ovf;
  logic [DCNT_W-1:0]  div_cnt;
  logic               div_used;
  logic               sums_sat;

  // Cell count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_cells <= '0;
    end else if (cfg_we) begin
      total_cells <= cfg_wdata;
    end
  end

  // Clearing pass address.
  assign status.clr_last = (clr_addr == GENE_W'(GENES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= status.clr_last ? '0 : clr_addr + 1'b1;
    end
  end

  // Request word capture.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      gene_reg  <= in_gene;
      value_reg <= in_value;
    end
  end

  // Saturating accumulate of the value and its square.
  assign value_sq = value_reg * value_reg;
  assign s1_sum   = {1'b0, rd_data.s1} + (S1_W + 1)'(value_reg);
  assign s2_sum   = {1'b0, rd_data.s2} + (S2_W + 1)'(value_sq);

  always_comb begin
    acc_entry.s1 = s1_sum[S1_W] ? '1 : s1_sum[S1_W-1:0];
    acc_entry.s2 = s2_sum[S2_W] ? '1 : s2_sum[S2_W-1:0];
  end

  // Sum table with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.acc_wr) begin
      mem[gene_reg] <= acc_entry;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[gene_reg];
    end
  end

  // Sums of the gene being read.
  always_ff @(posedge clk) begin
    if (cmd.load_sums) begin
      s1_reg <= rd_data.s1;
      s2_reg <= rd_data.s2;
    end
  end

  assign status.zero_case = (s1_reg == '0) || (total_cells == '0);
  assign sums_sat         = (s1_reg == '1) || (s2_reg == '1);

  // Shift-add multiplier, one multiplier bit per cycle.
  assign status.mul_done = (mul_b == '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_save) begin
      case (mul_sel_reg)
        MUL_NS2: prod_ns2 <= mul_acc[NS2_W-1:0];
        MUL_SQ:  prod_sq  <= mul_acc[SQ_W-1:0];
        MUL_NS1: prod_ns1 <= mul_acc[NS1_W-1:0];
        default: prod_ns1 <= mul_acc[NS1_W-1:0];
      endcase
    end
    if (cmd.mul_start) begin
      mul_acc     <= '0;
      mul_sel_reg <= cmd.mul_sel;
      case (cmd.mul_sel)
        MUL_NS2: begin
          mul_a <= MUL_P_W'(s2_reg);
          mul_b <= MUL_B_W'(total_cells);
        end
        MUL_SQ: begin
          mul_a <= MUL_P_W'(s1_reg);
          mul_b <= s1_reg;
        end
        default: begin
          mul_a <= MUL_P_W'(s1_reg);
          mul_b <= MUL_B_W'(total_cells);
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mul_b[0]) mul_acc <= mul_acc + mul_a;
      mul_a <= mul_a << 1;
      mul_b <= mul_b >> 1;
    end
  end

  assign status.num_pos = (prod_ns2 > NS2_W'(prod_sq));

  // Restoring divider, one quotient bit per cycle; bits beyond the range flag overflow.
  assign rem_sh = {rem, num_sh[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, prod_ns1});
  assign status.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_sh   <= {prod_ns2 - NS2_W'(prod_sq), {FRAC_SH{1'b0}}};
      rem      <= '0;
      quot     <= '0;
      quot_ovf <= 1'b0;
      div_cnt  <= DCNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem      <= rem_ge ? NS1_W'(rem_sh - {1'b0, prod_ns1}) : NS1_W'(rem_sh);
      quot     <= {quot[FANO_W-2:0], rem_ge};
      quot_ovf <= quot_ovf | quot[FANO_W-1];
      num_sh   <= num_sh << 1;
      div_cnt  <= div_cnt - 1'b1;
    end
  end

  // Marks whether the divider holds this read's quotient.
  always_ff @(posedge clk) begin
    if (rst || cmd.latch_in) begin
      div_used <= 1'b0;
    end else if (cmd.div_start) begin
      div_used <= 1'b1;
    end
  end

  // Result register; holds until the word is taken.
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gene_echo <= gene_reg;
      out_fano      <= div_used ? (quot_ovf ? '1 : quot) : '0;
      out_zero_mean <= status.zero_case;
      out_saturated <= sums_sat || (div_used && quot_ovf);
    end
  end

endmodule

>>> src/per_gene_fano_accumulator_unit.sv
// Top level of the per-gene Fano factor accumulator.
//
//   channel   direction  carries
//   req_ch    in         req_type, gene, value
//   res_ch    out        gene_echo, fano, zero_mean, saturated
//   cfg       in         total_cells (cfg_we, cfg_wdata)
//
// An accumulate word passes through accept, table read and table write.
// A read word's duration is set mostly by the shared shift-add multiplier (one bit per cycle)
// and the 89-step restoring divider.
// Reset and every clear word start a clearing pass of 4096 cycles over the sum table,
// during which no word is accepted; configuration writes are taken at any time.
// A finished result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
module per_gene_fano_accumulator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fga_pkg::CELLS_W-1:0] cfg_wdata,
  fga_req_if.sink                     req_ch,
  fga_res_if.source                   res_ch
);
  import fga_pkg::*;

  cmd_t    cmd;
  status_t status;
  state_t  state;

  // Controller.
  fga_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req_ch.valid),
    .in_req_type (req_ch.req_type),
    .status      (status),
    .in_ready    (req_ch.ready),
    .cmd         (cmd),
    .state       (state)
  );

  // Datapath.
  fga_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_gene       (req_ch.gene),
    .in_value      (req_ch.value),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (res_ch.ready),
    .out_valid     (res_ch.valid),
    .out_gene_echo (res_ch.gene_echo),
    .out_fano      (res_ch.fano),
    .out_zero_mean (res_ch.zero_mean),
    .out_saturated (res_ch.saturated)
  );

`ifndef SYNTHESIS
  // A clear word blocks new words while the table is swept.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    req_ch.valid && req_ch.ready && req_ch.req_type == REQ_CLEAR |=> !req_ch.ready)
    else $error("word accepted right after a clear");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !res_ch.valid || res_ch.ready)
    else $error("result register overwritten");

  // The table is never written from two sources at once.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_wr |-> !cmd.clr_wr && state == ST_ACC_WR)
    else $error("conflicting table writes");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the per-gene Fano factor accumulator.
`timescale 1ns / 1ps
module tb_top;
  import fga_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int CLEAR_WAIT   = 4300;
  localparam int RAND_WORDS   = 350;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [FANO_W-1:0] FANO_MAX = {FANO_W{1'b1}};
  localparam logic [S1_W-1:0] S1_MAX = {S1_W{1'b1}};
  localparam logic [S2_W-1:0] S2_MAX = {S2_W{1'b1}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {VALUE_W{1'b1}};

  typedef struct packed {
    logic             drain;
    logic [REQ_W-1:0] kind;
    logic [GENE_W-1:0] gene;
    logic [VALUE_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic [GENE_W-1:0] gene;
    logic [FANO_W-1:0] fano;
    logic              zero_mean;
    logic              saturated;
  } fano_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CELLS_W-1:0] cfg_wdata;

  fga_req_if req_ch ();
  fga_res_if res_ch ();

  per_gene_fano_accumulator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_ch    (req_ch),
    .res_ch    (res_ch)
  );

  // Mirror of the gene table and the cell count.
  logic [S1_W-1:0]    gene_s1 [GENES];
  logic [S2_W-1:0]    gene_s2 [GENES];
  logic [CELLS_W-1:0] cells_n;

  req_word_t  pending_q[$];
  fano_word_t fano_expect_q[$];

  int errors;
  int acc_cnt;
  int read_cnt;
  int clear_cnt;
  int hold_req;
  int hold_done;
  bit quiet;
  int cycle_cnt;

  // Clock, and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ACC;
    req_ch.gene = '0;
    req_ch.value = '0;
    res_ch.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  // Updates the table for one accepted word and queues the Fano result of a read.
  function automatic void apply_request(input req_word_t w);
    logic [127:0] ns2, sq, num, den, quo;
    logic [S1_W:0] s1_sum;
    logic [S2_W:0] s2_sum;
    fano_word_t r;
    case (w.kind)
      REQ_ACC: begin
        s1_sum = {1'b0, gene_s1[w.gene]} + (S1_W+1)'(w.value);
        s2_sum = {1'b0, gene_s2[w.gene]} + (S2_W+1)'(w.value) * (S2_W+1)'(w.value);
        gene_s1[w.gene] = s1_sum[S1_W] ? S1_MAX : s1_sum[S1_W-1:0];
        gene_s2[w.gene] = s2_sum[S2_W] ? S2_MAX : s2_sum[S2_W-1:0];
        acc_cnt++;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < GENES; i++) begin
          gene_s1[i] = '0;
          gene_s2[i] = '0;
        end
        clear_cnt++;
      end
      REQ_READ: begin
        r.gene = w.gene;
        r.fano = '0;
        r.zero_mean = 1'b0;
        r.saturated = (gene_s1[w.gene] == S1_MAX) || (gene_s2[w.gene] == S2_MAX);
        if (gene_s1[w.gene] == '0 || cells_n == '0) begin
          r.zero_mean = 1'b1;
        end else begin
          ns2 = 128'(cells_n) * 128'(gene_s2[w.gene]);
          sq  = 128'(gene_s1[w.gene]) * 128'(gene_s1[w.gene]);
          // A negative numerator is clamped, leaving the Fano factor at zero.
          if (ns2 > sq) begin
            num = (ns2 - sq) << FRAC_SH;
            den = 128'(cells_n) * 128'(gene_s1[w.gene]);
            quo = num / den;
            if (quo > 128'(FANO_MAX)) begin
              r.fano = FANO_MAX;
              r.saturated = 1'b1;
            end else begin
              r.fano = quo[FANO_W-1:0];
            end
          end
        end
        fano_expect_q.push_back(r);
        read_cnt++;
      end
      default: ;
    endcase
  endfunction

  function automatic req_word_t make_word(input logic [REQ_W-1:0] kind,
                                          input int gene, input int value);
    req_word_t w;
    w.drain = 1'b0;
    w.kind = kind;
    w.gene = GENE_W'(gene);
    w.value = VALUE_W'(value);
    return w;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 94) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Request driver: offers queued words, with random gaps between them.
  int gap_cnt;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_cnt <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && fano_expect_q.size() != 0)) begin
        req_ch.valid <= 1'b1;
        req_ch.req_type <= pending_q[0].kind;
        req_ch.gene <= pending_q[0].gene;
        req_ch.value <= pending_q[0].value;
        void'(pending_q.pop_front());
        gap_cnt <= pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Prediction on every accepted request word.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      apply_request(make_word(req_ch.req_type, req_ch.gene, req_ch.value));
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  int stall_cnt;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done <= hold_req;
      stall_cnt <= 800;
      res_ch.ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      res_ch.ready <= 1'b1;
    end else begin
      stall_cnt <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      res_ch.ready <= 1'b0;
    end
  end

  // Result checker against the oldest expected word.
  always @(posedge clk) begin
    fano_word_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (fano_expect_q.size() == 0) begin
        $display("%0t: unexpected result gene %0d fano %0d", $time,
                 res_ch.gene_echo, res_ch.fano);
        errors++;
      end else begin
        e = fano_expect_q.pop_front();
        if (res_ch.gene_echo !== e.gene || res_ch.fano !== e.fano ||
            res_ch.zero_mean !== e.zero_mean || res_ch.saturated !== e.saturated) begin
          // Fields are gene, fano, zero mean and saturated, in that order.
          $display("%0t: mismatch expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
                   $time, e.gene, e.fano, e.zero_mean, e.saturated, res_ch.gene_echo,
                   res_ch.fano, res_ch.zero_mean, res_ch.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    #1;
    while (pending_q.size() != 0 || req_ch.valid || fano_expect_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // Waits out any clear or accumulate in flight, then sets the cell count.
  task automatic set_cells(input logic [CELLS_W-1:0] n);
    wait_drained();
    repeat (CLEAR_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    cells_n = n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    req_word_t w;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 999);
      w.kind = (p < 760) ? REQ_ACC : (p < 960) ? REQ_READ : (p < 970) ? REQ_CLEAR : REQ_UNUSED;
      // Most words hit a few hot genes so that reads find data.
      w.gene = ($urandom_range(0, 3) != 0) ? GENE_W'($urandom_range(0, 15))
                                           : GENE_W'($urandom);
      p = $urandom_range(0, 9);
      w.value = (p < 5) ? VALUE_W'($urandom) : (p < 8) ? VALUE_W'($urandom_range(1, 4096))
              : (p < 9) ? VAL_MAX : '0;
      w.drain = ($urandom_range(0, 99) < 2);
      pending_q.push_back(w);
    end
  endtask

  initial begin
    errors = 0;
    acc_cnt = 0;
    read_cnt = 0;
    clear_cnt = 0;
    hold_req = 0;
    hold_done = 0;
    quiet = 0;
    cycle_cnt = 0;
    cells_n = '0;
    for (int i = 0; i < GENES; i++) begin
      gene_s1[i] = '0;
      gene_s2[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero cell count: every read reports a zero mean.
    set_cells('0);
    pending_q.push_back(make_word(REQ_ACC, 0, VAL_MAX));
    pending_q.push_back(make_word(REQ_READ, 0, 0));
    pending_q.push_back(make_word(REQ_READ, 4095, 0));
    pending_q.push_back(make_word(REQ_UNUSED, 4095, VAL_MAX));
    pending_q.push_back(make_word(REQ_ACC, 4095, 1));

    // One cell: zero variance, and a numerator that goes negative.
    set_cells(CELLS_W'(1));
    pending_q.push_back(make_word(REQ_READ, 0, 0));
    pending_q.push_back(make_word(REQ_ACC, 5, 768));
    pending_q.push_back(make_word(REQ_ACC, 5, 1280));
    pending_q.push_back(make_word(REQ_READ, 5, 0));
    pending_q.push_back(make_word(REQ_READ, 4095, 0));
    pending_q.push_back(make_word(REQ_ACC, 7, 0));
    pending_q.push_back(make_word(REQ_READ, 7, 0));
    pending_q.push_back(make_word(REQ_CLEAR, 0, 0));
    pending_q.push_back(make_word(REQ_READ, 0, 0));
    pending_q.push_back(make_word(REQ_READ, 5, 0));

    // Cell count of 1048576.
    set_cells(CELLS_W'(1048576));
    pending_q.push_back(make_word(REQ_ACC, 1, VAL_MAX));
    pending_q.push_back(make_word(REQ_ACC, 1, 1));
    pending_q.push_back(make_word(REQ_ACC, 1, 256));
    pending_q.push_back(make_word(REQ_READ, 1, 0));
    pending_q.push_back(make_word(REQ_ACC, 2, VAL_MAX));
    pending_q.push_back(make_word(REQ_READ, 2, 0));

    // Random phases over several cell counts.
    set_cells(CELLS_W'($urandom_range(2, 1048576)));
    queue_random(RAND_WORDS);
    set_cells(CELLS_W'(1048575));
    hold_req++;
    queue_random(RAND_WORDS);
    set_cells(CELLS_W'(2));
    quiet = 1;
    queue_random(RAND_WORDS);
    wait_drained();
    quiet = 0;
    set_cells(CELLS_W'($urandom_range(3, 64)));
    queue_random(RAND_WORDS);
    set_cells(CELLS_W'($urandom));
    queue_random(RAND_WORDS);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d accumulates, %0d Fano reads and %0d clears", acc_cnt, read_cnt,
             clear_cnt);
    $display("over cell counts from zero to the maximum, with random stalls on both sides.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
